@@ rtl/stfp_pkg.sv @@
package stfp_pkg;

  // Coordinate width of the input fields and widths of the exact integer datapath.
  localparam int COORD_BITS = 12;
  localparam int OUT_W      = 48;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int COF_W      = 2 * COORD_BITS + 3;
  localparam int RHS_W      = 2 * COORD_BITS + 3;
  localparam int DET_W      = 3 * COORD_BITS + 4;
  localparam int HN_W       = 4 * COORD_BITS + 6;
  localparam int NUM_W      = 5 * COORD_BITS + 7;
  localparam int DEN_W      = DET_W;
  localparam int QUO_W      = OUT_W + 1;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;
    logic signed [COORD_BITS-1:0] dz;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] coef_a;
    logic signed [OUT_W-1:0] coef_b;
    logic signed [OUT_W-1:0] coef_c;
    logic signed [OUT_W-1:0] coef_d;
    logic                    degenerate;
    logic                    saturated;
  } out_t;

  // Classified beat handed from the front end to the back end.
  typedef struct packed {
    logic [8:0][COF_W-1:0]      cof;
    logic [2:0][RHS_W-1:0]      rhs;
    logic [2:0][COORD_BITS-1:0] pa;
    logic [DET_W-1:0]           det;
    logic                       degen;
  } rec_t;

  // One lane of the restoring divider pipeline.
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] nq;
  } div_t;

  // Cyclic successor modulo three.
  function automatic int nxt3(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

endpackage

@@ rtl/stfp_front.sv @@
module stfp_front import stfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic q_space,
  output logic push,
  output rec_t push_rec
);

  logic adv;
  logic signed [COORD_BITS-1:0] p [4][3];
  logic signed [DIFF_W-1:0] d_nxt [3][3];
  logic signed [DIFF_W-1:0] d1_r [3][3];
  logic signed [DIFF_W-1:0] d2_r [3][3];
  logic signed [COORD_BITS-1:0] a1_r [3];
  logic signed [COORD_BITS-1:0] a2_r [3];
  logic signed [COORD_BITS-1:0] a3_r [3];
  logic signed [COORD_BITS-1:0] a4_r [3];
  logic signed [PROD_W-1:0] pa_nxt [3][3];
  logic signed [PROD_W-1:0] pb_nxt [3][3];
  logic signed [PROD_W-1:0] sq_nxt [3][3];
  logic signed [PROD_W-1:0] pa_r [3][3];
  logic signed [PROD_W-1:0] pb_r [3][3];
  logic signed [PROD_W-1:0] sq_r [3][3];
  logic signed [COF_W-1:0] cof_nxt [3][3];
  logic signed [COF_W-1:0] cof3_r [3][3];
  logic signed [COF_W-1:0] cof4_r [3][3];
  logic signed [RHS_W-1:0] rhs_nxt [3];
  logic signed [RHS_W-1:0] rhs3_r [3];
  logic signed [RHS_W-1:0] rhs4_r [3];
  logic signed [DET_W-1:0] td_nxt [3];
  logic signed [DET_W-1:0] td_r [3];
  logic signed [DET_W-1:0] det_r;
  logic v1_r, v2_r, v3_r, v4_r;

  assign adv      = q_space;
  assign in_ready = adv;

  // Edge vectors of B, C and D relative to A.
  always_comb begin
    p[0][0] = COORD_BITS'(in_data.ax);
    p[0][1] = COORD_BITS'(in_data.ay);
    p[0][2] = COORD_BITS'(in_data.az);
    p[1][0] = COORD_BITS'(in_data.bx);
    p[1][1] = COORD_BITS'(in_data.by_coord);
    p[1][2] = COORD_BITS'(in_data.bz);
    p[2][0] = COORD_BITS'(in_data.cx);
    p[2][1] = COORD_BITS'(in_data.cy);
    p[2][2] = COORD_BITS'(in_data.cz);
    p[3][0] = COORD_BITS'(in_data.dx);
    p[3][1] = COORD_BITS'(in_data.dy);
    p[3][2] = COORD_BITS'(in_data.dz);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        d_nxt[i][k] = DIFF_W'(p[i + 1][k]) - DIFF_W'(p[0][k]);
      end
    end
  end

  // Pairwise products for the cofactors, and squares for the right side.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        pa_nxt[i][k] = d1_r[nxt3(i)][nxt3(k)] * d1_r[nxt3(nxt3(i))][nxt3(nxt3(k))];
        pb_nxt[i][k] = d1_r[nxt3(i)][nxt3(nxt3(k))] * d1_r[nxt3(nxt3(i))][nxt3(k)];
        sq_nxt[i][k] = d1_r[i][k] * d1_r[i][k];
      end
    end
  end

  // Signed cofactors, right side and the determinant terms along the first row.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rhs_nxt[i] = -(RHS_W'(sq_r[i][0]) + RHS_W'(sq_r[i][1]) + RHS_W'(sq_r[i][2]));
      for (int k = 0; k < 3; k++) begin
        cof_nxt[i][k] = COF_W'(pa_r[i][k]) - COF_W'(pb_r[i][k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      td_nxt[k] = d2_r[0][k] * cof_nxt[0][k];
    end
  end

  // Pipeline registers; every stage moves together when the queue has room.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a1_r[i]   <= p[0][i];
        a2_r[i]   <= a1_r[i];
        a3_r[i]   <= a2_r[i];
        a4_r[i]   <= a3_r[i];
        rhs3_r[i] <= rhs_nxt[i];
        rhs4_r[i] <= rhs3_r[i];
        td_r[i]   <= td_nxt[i];
        for (int k = 0; k < 3; k++) begin
          d1_r[i][k]   <= d_nxt[i][k];
          d2_r[i][k]   <= d1_r[i][k];
          pa_r[i][k]   <= pa_nxt[i][k];
          pb_r[i][k]   <= pb_nxt[i][k];
          sq_r[i][k]   <= sq_nxt[i][k];
          cof3_r[i][k] <= cof_nxt[i][k];
          cof4_r[i][k] <= cof3_r[i][k];
        end
      end
      det_r <= td_r[0] + td_r[1] + td_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Classify the beat as degenerate when the determinant is zero.
  assign push = v4_r && adv;
  always_comb begin
    push_rec = '0;
    for (int i = 0; i < 3; i++) begin
      push_rec.rhs[i] = rhs4_r[i];
      push_rec.pa[i]  = a4_r[i];
      for (int k = 0; k < 3; k++) begin
        push_rec.cof[i * 3 + k] = cof4_r[i][k];
      end
    end
    push_rec.det   = det_r;
    push_rec.degen = (det_r == '0);
  end

endmodule

@@ rtl/stfp_queue.sv @@
module stfp_queue import stfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head,
  output logic head_valid,
  output logic space
);

  rec_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_r];
  assign head_valid = (cnt_r != '0);
  assign space      = (cnt_r != QCNT_W'(QDEPTH)) || pop;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = push ? ((wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + QPTR_W'(1)) : wr_r;
    rd_nxt  = pop ? ((rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + QPTR_W'(1)) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_rec;
    end
  end

endmodule

@@ rtl/stfp_back.sv @@
module stfp_back import stfp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  rec_t head,
  input  logic head_valid,
  output logic pop,
  output out_t out_data,
  output logic out_valid,
  input  logic out_ready
);

  localparam int A2_W  = 2 * COORD_BITS + 2;
  localparam int MAG_W = NUM_W + FRAC_BITS;
  localparam int TOP_W = MAG_W - QUO_W;
  localparam int CMP_W = (TOP_W > DEN_W) ? TOP_W : DEN_W;

  logic adv;

  logic signed [2*COF_W-1:0]          prod_r [3][3];
  logic signed [COORD_BITS+DET_W-1:0] ca_r [3];
  logic signed [2*COORD_BITS-1:0]     asq_r [3];
  logic signed [COORD_BITS-1:0]       a1_r [3];
  logic signed [COORD_BITS-1:0]       a2_r [3];
  logic signed [DET_W-1:0]            det1_r, det2_r, det3_r, det4_r;
  logic signed [HN_W-1:0]             gn_nxt [3];
  logic signed [HN_W-1:0]             gn2_r [3];
  logic signed [HN_W-1:0]             gn3_r [3];
  logic signed [HN_W-1:0]             gn4_r [3];
  logic signed [A2_W-1:0]             a22_r;
  logic signed [HN_W+COORD_BITS-1:0]  gc3_r [3];
  logic signed [A2_W+DET_W-1:0]       a2d3_r;
  logic signed [NUM_W-1:0]            dn4_r;
  logic dg1_r, dg2_r, dg3_r, dg4_r;
  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [NUM_W-1:0] num [4];
  logic [NUM_W-1:0]        nmag [4];
  logic [MAG_W-1:0]        smag [4];
  logic [TOP_W-1:0]        top [4];
  logic [DEN_W-1:0]        den0;
  logic                    dneg;
  div_t                    dv0 [4];

  div_t             dv_r [QUO_W+1][4];
  div_t             dv_nxt [QUO_W][4];
  logic [DEN_W-1:0] den_r [QUO_W+1];
  logic             dgd_r [QUO_W+1];
  logic             vd_r [QUO_W+1];

  logic [QUO_W:0]          qr [4];
  logic [QUO_W:0]          lim [4];
  logic                    sat [4];
  logic [OUT_W-1:0]        mg [4];
  logic signed [OUT_W-1:0] val [4];
  logic                    up [4];
  out_t                    out_nxt;
  out_t                    out_r;
  logic                    ov_r;

  assign adv       = !ov_r || out_ready;
  assign pop       = adv && head_valid;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Cofactor expansion products, the A terms and the numerator sums.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod_r[i][k] <= $signed(head.rhs[i]) * $signed(head.cof[i * 3 + k]);
        end
        ca_r[k]  <= $signed(head.pa[k]) * $signed(head.det);
        asq_r[k] <= $signed(head.pa[k]) * $signed(head.pa[k]);
        a1_r[k]  <= $signed(head.pa[k]);
        a2_r[k]  <= a1_r[k];
        gn2_r[k] <= gn_nxt[k];
        gn3_r[k] <= gn2_r[k];
        gn4_r[k] <= gn3_r[k];
        gc3_r[k] <= gn2_r[k] * a2_r[k];
      end
      det1_r <= $signed(head.det);
      det2_r <= det1_r;
      det3_r <= det2_r;
      det4_r <= det3_r;
      a22_r  <= A2_W'(asq_r[0]) + A2_W'(asq_r[1]) + A2_W'(asq_r[2]);
      a2d3_r <= a22_r * det2_r;
      dn4_r  <= -NUM_W'(a2d3_r) - NUM_W'(gc3_r[0]) - NUM_W'(gc3_r[1]) - NUM_W'(gc3_r[2]);
      dg1_r  <= head.degen;
      dg2_r  <= dg1_r;
      dg3_r  <= dg2_r;
      dg4_r  <= dg3_r;
    end
  end

  // Linear coefficient numerators: G = H - 2 A det.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gn_nxt[k] = HN_W'(prod_r[0][k]) + HN_W'(prod_r[1][k]) + HN_W'(prod_r[2][k])
                - (HN_W'(ca_r[k]) <<< 1);
    end
  end

  // Divider setup: magnitudes, result sign and quotient overflow check.
  always_comb begin
    num[0] = NUM_W'(gn4_r[0]);
    num[1] = NUM_W'(gn4_r[1]);
    num[2] = NUM_W'(gn4_r[2]);
    num[3] = dn4_r;
    dneg   = det4_r[DET_W-1];
    den0   = dneg ? DEN_W'(-det4_r) : DEN_W'(det4_r);
    for (int c = 0; c < 4; c++) begin
      nmag[c]    = num[c][NUM_W-1] ? NUM_W'(-num[c]) : NUM_W'(num[c]);
      smag[c]    = MAG_W'(nmag[c]) << FRAC_BITS;
      top[c]     = smag[c][MAG_W-1:QUO_W];
      dv0[c].neg = num[c][NUM_W-1] ^ dneg;
      dv0[c].ovf = CMP_W'(top[c]) >= CMP_W'(den0);
      dv0[c].rem = dv0[c].ovf ? '0 : DEN_W'(top[c]);
      dv0[c].nq  = smag[c][QUO_W-1:0];
    end
  end

  // One restoring quotient bit per stage.
  always_comb begin
    logic [DEN_W:0] trial;
    logic           ge;
    for (int s = 0; s < QUO_W; s++) begin
      for (int c = 0; c < 4; c++) begin
        trial = {dv_r[s][c].rem, dv_r[s][c].nq[QUO_W-1]};
        ge    = trial >= {1'b0, den_r[s]};
        if (ge) begin
          trial = trial - {1'b0, den_r[s]};
        end
        dv_nxt[s][c].neg = dv_r[s][c].neg;
        dv_nxt[s][c].ovf = dv_r[s][c].ovf;
        dv_nxt[s][c].rem = trial[DEN_W-1:0];
        dv_nxt[s][c].nq  = {dv_r[s][c].nq[QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0]  <= dv0;
      den_r[0] <= den0;
      dgd_r[0] <= dg4_r;
      for (int s = 0; s < QUO_W; s++) begin
        dv_r[s + 1]  <= dv_nxt[s];
        den_r[s + 1] <= den_r[s];
        dgd_r[s + 1] <= dgd_r[s];
      end
    end
  end

  // Round half away from zero, saturate and apply the sign.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      up[c]  = {dv_r[QUO_W][c].rem, 1'b0} >= {1'b0, den_r[QUO_W]};
      qr[c]  = (QUO_W + 1)'(dv_r[QUO_W][c].nq) + (QUO_W + 1)'(up[c]);
      lim[c] = ((QUO_W + 1)'(1) << (OUT_W - 1)) - (QUO_W + 1)'(!dv_r[QUO_W][c].neg);
      sat[c] = dv_r[QUO_W][c].ovf || (qr[c] > lim[c]);
      mg[c]  = sat[c] ? lim[c][OUT_W-1:0] : qr[c][OUT_W-1:0];
      val[c] = dv_r[QUO_W][c].neg ? -$signed(mg[c]) : $signed(mg[c]);
    end
    if (dgd_r[QUO_W]) begin
      out_nxt            = '0;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.coef_a     = val[0];
      out_nxt.coef_b     = val[1];
      out_nxt.coef_c     = val[2];
      out_nxt.coef_d     = val[3];
      out_nxt.degenerate = 1'b0;
      out_nxt.saturated  = sat[0] || sat[1] || sat[2] || sat[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  // Valid bits of the back-end pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
      for (int s = 0; s <= QUO_W; s++) begin
        vd_r[s] <= 1'b0;
      end
    end else if (adv) begin
      v1_r    <= head_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      vd_r[0] <= v4_r;
      for (int s = 0; s < QUO_W; s++) begin
        vd_r[s + 1] <= vd_r[s];
      end
      ov_r <= vd_r[QUO_W];
    end
  end

endmodule

@@ rtl/sphere_through_four_points_top.sv @@
// Throughput: one beat per cycle while out_ready stays high, set by the fully pipelined
// multiplier stages and the 49-stage restoring divider, one quotient bit per stage.
// A four-entry queue between the front end and the divider back end absorbs stalls.
// Reset: synchronous, active-low rst_n clears all valid bits and the queue; no beat
// is held after reset.
module sphere_through_four_points_top import stfp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  logic in_valid,
  output logic in_ready,
  output out_t out_data,
  output logic out_valid,
  input  logic out_ready
);

  logic q_space;
  logic push;
  rec_t push_rec;
  logic pop;
  rec_t head;
  logic head_valid;

  stfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_space  (q_space),
    .push     (push),
    .push_rec (push_rec)
  );

  stfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .space      (q_space)
  );

  stfp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_data   (out_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule
